/* design/lbs_pkg.sv */
package lbs_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_LIMIT = 1'b1;

  localparam int unsigned LEAK_W  = 16;
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned SIZE_W  = 16;

  localparam logic [LEAK_W-1:0]  LEAK_RATE_RST    = 16'd1000;
  localparam logic [LIMIT_W-1:0] BUCKET_LIMIT_RST = 20'd10000;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  // Most results one tick may produce
  localparam int unsigned MAX_OUT   = 16;
  localparam int unsigned OUT_CNT_W = $clog2(MAX_OUT);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_ACCEPT  = 3'd0,
    EV_REJECT  = 3'd1,
    EV_SENT    = 3'd2,
    EV_PARTIAL = 3'd3,
    EV_EMPTY   = 3'd4
  } event_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] remaining;
  } entry_t;

endpackage

/* design/lbs_queue_mem.sv */
module lbs_queue_mem
  import lbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [PTR_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/leaky_bucket_packet_shaper.sv */
// An add gives its single word in the cycle after acceptance; an empty tick likewise.
// A tick first reads the head, then gives one result word per cycle while the output is
// not stalled, paced by the one registered read port of the queue memory.
// One item is processed at a time; a new item is taken once the last word is registered and the output is free.
// Reset (rst_n low, synchronous) empties the queue, zeroes bytes held and restores
// leak_rate = 1000 and bucket_limit = 10000; queue storage itself is not cleared.
module leaky_bucket_packet_shaper
  import lbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [ID_W-1:0]      in_packet_id,
  input  logic [SIZE_W-1:0]    in_packet_size,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_res,
  output logic [ID_W-1:0]      out_result_id,
  output logic [SIZE_W-1:0]    out_remaining_size,
  output logic                 out_last,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_wdata
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_DRAIN
  } state_t;

  // Control and bucket state
  state_t              state_r,        state_nxt;
  logic [PTR_W-1:0]    head_r,         head_nxt;
  logic [PTR_W-1:0]    tail_r,         tail_nxt;
  logic [CNT_W-1:0]    count_r,        count_nxt;
  logic [LIMIT_W-1:0]  bytes_r,        bytes_nxt;
  logic [LEAK_W-1:0]   budget_r,       budget_nxt;
  logic [OUT_CNT_W-1:0] nsent_r,       nsent_nxt;
  logic [LEAK_W-1:0]   leak_rate_r;
  logic [LIMIT_W-1:0]  bucket_limit_r;

  // Output register
  logic                out_valid_r,    out_valid_nxt;
  event_t              out_event_r,    out_event_nxt;
  logic [ID_W-1:0]     out_id_r,       out_id_nxt;
  logic [SIZE_W-1:0]   out_rem_r,      out_rem_nxt;
  logic                out_last_r,     out_last_nxt;

  // Queue memory port
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [PTR_W-1:0]    mem_raddr;
  entry_t              head_entry;

  logic                out_free;
  logic                accept;
  logic [PTR_W-1:0]    head_inc;
  logic [PTR_W-1:0]    tail_inc;
  logic [LIMIT_W:0]    add_total;
  logic                queue_full;
  logic                last_pop;

  // The output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Pointers wrap explicitly so any depth in range works
  assign head_inc   = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign add_total  = {1'b0, bytes_r} + (LIMIT_W + 1)'(in_packet_size);
  assign queue_full = (count_r == CNT_W'(QUEUE_DEPTH));
  // Drain ends on the pop that empties the queue or fills the result cap
  assign last_pop   = (count_r == CNT_W'(1)) || (nsent_r == OUT_CNT_W'(MAX_OUT - 1));

  lbs_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_queue_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (head_entry)
  );

  // No forwarding is needed: an add writes the tail and a partial send writes
  // the head back, each at an earlier edge than any read of that entry.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    bytes_nxt     = bytes_r;
    budget_nxt    = budget_r;
    nsent_nxt     = nsent_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_event_nxt = out_event_r;
    out_id_nxt    = out_id_r;
    out_rem_nxt   = out_rem_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = '{id: in_packet_id, remaining: in_packet_size};
    mem_re        = 1'b0;
    mem_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_rem_nxt   = '0;
          if (in_operation == OP_ADD) begin
            out_id_nxt = in_packet_id;
            if (queue_full || (add_total > {1'b0, bucket_limit_r})) begin
              out_event_nxt = EV_REJECT;
            end else begin
              // Append at the tail
              mem_we        = 1'b1;
              tail_nxt      = tail_inc;
              count_nxt     = count_r + 1'b1;
              bytes_nxt     = add_total[LIMIT_W-1:0];
              out_event_nxt = EV_ACCEPT;
            end
          end else if (count_r == '0) begin
            out_event_nxt = EV_EMPTY;
            out_id_nxt    = '0;
          end else begin
            // Fetch the head and load a fresh budget; results follow from the drain
            out_valid_nxt = 1'b0;
            mem_re        = 1'b1;
            budget_nxt    = leak_rate_r;
            nsent_nxt     = '0;
            state_nxt     = S_DRAIN;
          end
        end
      end

      S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = head_entry.id;
          if (head_entry.remaining <= budget_r) begin
            // Whole packet fits: send it and pop
            budget_nxt    = budget_r - head_entry.remaining;
            bytes_nxt     = (bytes_r >= LIMIT_W'(head_entry.remaining))
                            ? bytes_r - LIMIT_W'(head_entry.remaining) : '0;
            out_event_nxt = EV_SENT;
            out_rem_nxt   = '0;
            out_last_nxt  = last_pop;
            head_nxt      = head_inc;
            count_nxt     = count_r - 1'b1;
            nsent_nxt     = nsent_r + 1'b1;
            if (last_pop) begin
              state_nxt = S_IDLE;
            end else begin
              // Prefetch the next head for the following cycle
              mem_re    = 1'b1;
              mem_raddr = head_inc;
            end
          end else begin
            // Budget runs out inside this packet: cut it down and write it back
            mem_we        = 1'b1;
            mem_waddr     = head_r;
            mem_wdata     = '{id: head_entry.id,
                              remaining: head_entry.remaining - budget_r};
            bytes_nxt     = (bytes_r >= LIMIT_W'(budget_r))
                            ? bytes_r - LIMIT_W'(budget_r) : '0;
            out_event_nxt = EV_PARTIAL;
            out_rem_nxt   = head_entry.remaining - budget_r;
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      bytes_r        <= '0;
      nsent_r        <= '0;
      out_valid_r    <= 1'b0;
      leak_rate_r    <= LEAK_RATE_RST;
      bucket_limit_r <= BUCKET_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      nsent_r     <= nsent_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEAK_RATE:    leak_rate_r    <= cfg_wdata[LEAK_W-1:0];
          CFG_BUCKET_LIMIT: bucket_limit_r <= cfg_wdata;
          default:          ;
        endcase
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    budget_r    <= budget_nxt;
    out_event_r <= out_event_nxt;
    out_id_r    <= out_id_nxt;
    out_rem_r   <= out_rem_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_event_r;
  assign out_result_id      = out_id_r;
  assign out_remaining_size = out_rem_r;
  assign out_last           = out_last_r;

endmodule

/* verif/lbs_checker.sv */
module lbs_checker
  import lbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_operation,
  input  logic [ID_W-1:0]      in_packet_id,
  input  logic [SIZE_W-1:0]    in_packet_size,

  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           out_event_res,
  input  logic [ID_W-1:0]      out_result_id,
  input  logic [SIZE_W-1:0]    out_remaining_size,
  input  logic                 out_last,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_wdata,

  output int unsigned          mismatch_count,
  output int unsigned          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 40;

  typedef struct {
    event_t            ev;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] rem;
    logic              last;
  } shaped_word_t;

  // Shadow copy of the shaper state
  logic [ID_W-1:0]    pkt_id   [QUEUE_DEPTH];
  logic [SIZE_W-1:0]  pkt_left [QUEUE_DEPTH];
  int unsigned        head_idx;
  int unsigned        tail_idx;
  int unsigned        queued;
  logic [LIMIT_W-1:0] held_bytes;
  logic [LEAK_W-1:0]  leak_rate;
  logic [LIMIT_W-1:0] bucket_limit;

  shaped_word_t expected_words [$];

  function automatic shaped_word_t word_of(event_t ev, logic [ID_W-1:0] id,
                                           logic [SIZE_W-1:0] rem, logic last);
    shaped_word_t w;
    w.ev   = ev;
    w.id   = id;
    w.rem  = rem;
    w.last = last;
    return w;
  endfunction

  // Work out the words one accepted input causes and advance the shadow state.
  task automatic shape_item(input logic op, input logic [ID_W-1:0] id,
                            input logic [SIZE_W-1:0] size);
    int unsigned  total;
    int unsigned  budget;
    int unsigned  left;
    int unsigned  emitted;
    shaped_word_t tail_word;
    if (op == OP_ADD) begin
      total = held_bytes + size;
      if (queued >= QUEUE_DEPTH || total > bucket_limit) begin
        expected_words.push_back(word_of(EV_REJECT, id, '0, 1'b1));
      end else begin
        pkt_id[tail_idx]   = id;
        pkt_left[tail_idx] = size;
        tail_idx   = (tail_idx + 1) % QUEUE_DEPTH;
        queued++;
        held_bytes = LIMIT_W'(total);
        expected_words.push_back(word_of(EV_ACCEPT, id, '0, 1'b1));
      end
    end else if (queued == 0) begin
      expected_words.push_back(word_of(EV_EMPTY, '0, '0, 1'b1));
    end else begin
      budget  = leak_rate;
      emitted = 0;
      while (queued > 0 && emitted < MAX_OUT) begin
        left = pkt_left[head_idx];
        if (left <= budget) begin
          budget    -= left;
          held_bytes = (held_bytes >= left) ? held_bytes - LIMIT_W'(left) : '0;
          expected_words.push_back(word_of(EV_SENT, pkt_id[head_idx], '0, 1'b0));
          head_idx = (head_idx + 1) % QUEUE_DEPTH;
          queued--;
          emitted++;
        end else begin
          left -= budget;
          pkt_left[head_idx] = SIZE_W'(left);
          held_bytes = (held_bytes >= budget) ? held_bytes - LIMIT_W'(budget) : '0;
          expected_words.push_back(word_of(EV_PARTIAL, pkt_id[head_idx],
                                           SIZE_W'(left), 1'b0));
          emitted++;
          break;
        end
      end
      tail_word      = expected_words.pop_back();
      tail_word.last = 1'b1;
      expected_words.push_back(tail_word);
    end
  endtask

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    shaped_word_t want;
    if (!rst_n) begin
      head_idx     = 0;
      tail_idx     = 0;
      queued       = 0;
      held_bytes   = '0;
      leak_rate    = LEAK_RATE_RST;
      bucket_limit = BUCKET_LIMIT_RST;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEAK_RATE:    leak_rate    = cfg_wdata[LEAK_W-1:0];
          CFG_BUCKET_LIMIT: bucket_limit = cfg_wdata;
          default: ;
        endcase
      end
      // Retire the result word first: a word leaving at this edge never
      // belongs to an input taken at the same edge.
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected word, expected none, got event %0d id %0d rem %0d last %0d",
                     $time, out_event_res, out_result_id, out_remaining_size, out_last);
        end else begin
          want = expected_words.pop_front();
          compare_field("event_res", 32'(want.ev), 32'(out_event_res));
          compare_field("result_id", 32'(want.id), 32'(out_result_id));
          compare_field("remaining_size", 32'(want.rem), 32'(out_remaining_size));
          compare_field("last", 32'(want.last), 32'(out_last));
        end
      end
      if (in_valid && in_ready)
        shape_item(in_operation, in_packet_id, in_packet_size);
    end
    words_pending = expected_words.size();
  end

endmodule

/* verif/tb_leaky_bucket_packet_shaper.sv */
module tb_leaky_bucket_packet_shaper;
  import lbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH         = DEF_QUEUE_DEPTH;
  // A tick drains at most DEPTH packets, one word per cycle after the head read while
  // the output is not stalled, so the settle wait covers anything still in flight.
  localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
  localparam int unsigned MAX_GAP       = 13;
  localparam int unsigned PHASE_ITEMS   = 29;
  localparam int unsigned LEAK_MAX      = 65535;
  localparam int unsigned LIMIT_MAX     = 1048575;

  logic                 clk;
  logic                 rst_n;

  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [ID_W-1:0]      in_packet_id;
  logic [SIZE_W-1:0]    in_packet_size;

  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_event_res;
  logic [ID_W-1:0]      out_result_id;
  logic [SIZE_W-1:0]    out_remaining_size;
  logic                 out_last;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_wdata;

  int unsigned          mismatch_count;
  int unsigned          words_pending;

  // Sender state: burst mode drops all gaps for a stretch of words.
  bit                   tx_steady;
  // Current shaping settings, used only to pick useful packet sizes
  int unsigned          cur_leak;
  int unsigned          cur_limit;

  leaky_bucket_packet_shaper #(.QUEUE_DEPTH(DEPTH)) u_dut (.*);

  lbs_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Present one word on the input channel and hold it until it is taken.
  // Entered and left at a falling edge; valid is left high so that a
  // back-to-back word can follow without a bubble.
  task automatic send_word(input logic op, input logic [ID_W-1:0] id,
                           input logic [SIZE_W-1:0] size);
    int unsigned gap;
    if ($urandom_range(11, 0) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_packet_id   <= id;
    in_packet_size <= size;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid, wait until every predicted word has come out, then let the
  // block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers; only ever called with the block idle.
  task automatic set_shaping(input int unsigned leak, input int unsigned limit);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEAK_RATE;
    cfg_wdata <= LIMIT_W'(leak);
    @(negedge clk);
    cfg_index <= CFG_BUCKET_LIMIT;
    cfg_wdata <= LIMIT_W'(limit);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_leak  = leak;
    cur_limit = limit;
  endtask

  // Mostly sizes that fit the bucket a few times over, with some zero-size
  // packets, some full-range sizes and some sizes equal to the leak budget.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned roll;
    int unsigned cap;
    roll = $urandom_range(99, 0);
    if (roll < 4) return '0;
    if (roll < 16) return SIZE_W'($urandom);
    if (roll < 26 && cur_leak != 0 && cur_leak <= LEAK_MAX) return SIZE_W'(cur_leak);
    cap = cur_limit / 5;
    if (cap > LEAK_MAX) cap = LEAK_MAX;
    if (cap == 0) cap = 1;
    return SIZE_W'($urandom_range(cap, 1));
  endfunction

  // Random mix of adds and ticks; once per phase hold off the sender until
  // every expected word has drained.
  task automatic run_random_phase(input int unsigned items);
    int unsigned pause_at;
    pause_at = $urandom_range(items - 1, 0);
    for (int i = 0; i < items; i++) begin
      if (i == pause_at) wait_idle();
      if ($urandom_range(99, 0) < 40)
        send_word(OP_TICK, ID_W'($urandom), SIZE_W'($urandom));
      else
        send_word(OP_ADD, ID_W'($urandom), pick_size());
    end
  endtask

  // Result side: stall a random number of cycles before each word, with
  // stretches of zero stall.
  initial begin : result_sink
    int unsigned stall;
    bit          steady;
    out_ready = 1'b0;
    steady    = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(11, 0) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(MAX_GAP, 0);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    in_valid       = 1'b0;
    in_operation   = OP_ADD;
    in_packet_id   = '0;
    in_packet_size = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_LEAK_RATE;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    tx_steady      = 1'b0;
    cur_leak       = LEAK_RATE_RST;
    cur_limit      = BUCKET_LIMIT_RST;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: leak 1000 bytes per tick, bucket of 10000 bytes.
    send_word(OP_TICK, 16'h1234, 16'hABCD);      // tick on an empty queue
    send_word(OP_ADD, 16'h0000, 16'h0000);       // zero-size packet
    send_word(OP_ADD, 16'hFFFF, 16'hFFFF);       // over the limit
    send_word(OP_ADD, 16'h0001, SIZE_W'(BUCKET_LIMIT_RST)); // fills bucket exactly
    send_word(OP_ADD, 16'h0002, 16'h0001);       // one byte over
    send_word(OP_TICK, 16'h0000, 16'h0000);      // zero-size sent, then partial

    // Widest settings: drain the leftover, then fill every slot.
    set_shaping(LEAK_MAX, LIMIT_MAX);
    send_word(OP_TICK, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < DEPTH; i++)
      send_word(OP_ADD, ID_W'(16'hA500 + i), (i == 0) ? 16'hFFFF : 16'h0001);
    send_word(OP_ADD, 16'hFFFF, 16'h0001);       // queue full
    // Head uses the whole budget, next head goes out partial and unchanged.
    send_word(OP_TICK, 16'h5A5A, 16'h5A5A);

    // Zero leak: the head is reported partial with nothing taken off.
    set_shaping(0, LIMIT_MAX);
    send_word(OP_TICK, 16'h0000, 16'h0000);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       set_shaping(LEAK_RATE_RST, BUCKET_LIMIT_RST);
        1:       set_shaping(LEAK_MAX, LIMIT_MAX);
        2:       set_shaping(1, 0);
        3:       set_shaping(0, 3000);
        4:       set_shaping($urandom_range(LEAK_MAX, 1), $urandom_range(LIMIT_MAX, 0));
        5:       set_shaping(300, 4000);
        default: set_shaping($urandom_range(2000, 1), $urandom_range(200000, 1000));
      endcase
      run_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("leaky_bucket_packet_shaper verification clean");
    end else begin
      $display("leaky_bucket_packet_shaper verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("leaky_bucket_packet_shaper verification failed");
    $finish;
  end

endmodule
